[src/cdcs_pkg.sv]
package cdcs_pkg;

	// item kinds on the slave side tuser
	typedef enum logic [2:0] {
		KIND_EVENT = 3'd0,
		KIND_READ  = 3'd1,
		KIND_SEEK  = 3'd2,
		KIND_MODE  = 3'd3,
		KIND_CHAN  = 3'd4
	} kind_t;

	typedef enum logic [3:0] {
		ST_IDLE        = 4'd0,
		ST_READ_SETLOC = 4'd1,
		ST_READ_WAIT   = 4'd2,
		ST_SEEK_SETLOC = 4'd3,
		ST_SEEK_WAIT   = 4'd4,
		ST_DONE        = 4'd5,
		ST_READ_RETRY  = 4'd6,
		ST_HALT        = 4'd7,
		ST_AUDIO_MODE  = 4'd8,
		ST_AUDIO_FILT  = 4'd9,
		ST_RESET_MODE  = 4'd10,
		ST_ERROR       = 4'd11,
		ST_HANDLE_ERR  = 4'd12
	} seq_state_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_SEEK    = 3'd1,
		ERR_GENERIC = 3'd2,
		ERR_READ    = 3'd3,
		ERR_HALT    = 3'd4,
		ERR_AUDIO   = 3'd5,
		ERR_RESET   = 3'd6
	} err_t;

	typedef enum logic [3:0] {
		CMD_SETLOC    = 4'd0,
		CMD_READN     = 4'd1,
		CMD_SEEKL     = 4'd2,
		CMD_PAUSE     = 4'd3,
		CMD_NOP       = 4'd4,
		CMD_STOP      = 4'd5,
		CMD_SETMODE   = 4'd6,
		CMD_SETFILTER = 4'd7,
		CMD_GETTN     = 4'd8
	} cmd_t;

	localparam logic [7:0] FILTER_FILE = 8'd1;

	typedef struct packed {
		logic [2:0]  kind;
		logic        status_complete;
		logic        shell_open;
		logic [31:0] target_location;
		logic        pause_instead;
		logic [7:0]  mode_byte;
		logic [7:0]  channel_number;
	} item_t;

	typedef struct packed {
		seq_state_t  seq;
		logic [2:0]  err;
		logic [31:0] loc;
		logic [7:0]  mode;
		logic [7:0]  chan;
	} ctx_t;

	typedef struct packed {
		logic        command_valid;
		logic [3:0]  command_code;
		logic [31:0] command_location;
		logic [7:0]  command_byte_a;
		logic [7:0]  command_byte_b;
		logic [3:0]  drive_state;
		logic [2:0]  last_error;
		logic        idle;
	} result_t;

endpackage

[src/cdcs_step.sv]
module cdcs_step (
	input  cdcs_pkg::item_t   item,
	input  cdcs_pkg::ctx_t    cur,
	output cdcs_pkg::ctx_t    nxt,
	output cdcs_pkg::result_t res
);

	cdcs_pkg::cmd_t code;
	logic           issue;

	// next state and command choice
	always_comb begin
		nxt   = cur;
		issue = 1'b0;
		code  = cdcs_pkg::CMD_SETLOC;
		unique case (item.kind)
			cdcs_pkg::KIND_EVENT: begin
				unique case (cur.seq)
					cdcs_pkg::ST_IDLE: begin
					end
					cdcs_pkg::ST_READ_SETLOC,
					cdcs_pkg::ST_SEEK_SETLOC,
					cdcs_pkg::ST_READ_RETRY,
					cdcs_pkg::ST_HALT,
					cdcs_pkg::ST_AUDIO_MODE,
					cdcs_pkg::ST_AUDIO_FILT,
					cdcs_pkg::ST_RESET_MODE: begin
						issue = 1'b1;
						if (item.status_complete) begin
							unique case (cur.seq)
								cdcs_pkg::ST_READ_SETLOC: begin
									nxt.seq = cdcs_pkg::ST_READ_WAIT;
									code    = cdcs_pkg::CMD_READN;
								end
								cdcs_pkg::ST_SEEK_SETLOC: begin
									nxt.seq = cdcs_pkg::ST_SEEK_WAIT;
									code    = cdcs_pkg::CMD_SEEKL;
								end
								cdcs_pkg::ST_READ_RETRY,
								cdcs_pkg::ST_AUDIO_FILT: begin
									nxt.seq = cdcs_pkg::ST_READ_SETLOC;
									code    = cdcs_pkg::CMD_SETLOC;
								end
								cdcs_pkg::ST_HALT: begin
									nxt.seq = cdcs_pkg::ST_READ_RETRY;
									code    = cdcs_pkg::CMD_PAUSE;
								end
								cdcs_pkg::ST_AUDIO_MODE: begin
									nxt.seq = cdcs_pkg::ST_AUDIO_FILT;
									code    = cdcs_pkg::CMD_SETFILTER;
								end
								default: begin
									nxt.seq = cdcs_pkg::ST_DONE;
									code    = cdcs_pkg::CMD_PAUSE;
								end
							endcase
						end else begin
							nxt.seq = cdcs_pkg::ST_ERROR;
							code    = cdcs_pkg::CMD_NOP;
							unique case (cur.seq)
								cdcs_pkg::ST_SEEK_SETLOC: nxt.err = cdcs_pkg::ERR_SEEK;
								cdcs_pkg::ST_HALT:        nxt.err = cdcs_pkg::ERR_HALT;
								cdcs_pkg::ST_AUDIO_MODE,
								cdcs_pkg::ST_AUDIO_FILT:  nxt.err = cdcs_pkg::ERR_AUDIO;
								cdcs_pkg::ST_RESET_MODE:  nxt.err = cdcs_pkg::ERR_RESET;
								default:                  nxt.err = cdcs_pkg::ERR_READ;
							endcase
						end
					end
					cdcs_pkg::ST_READ_WAIT,
					cdcs_pkg::ST_SEEK_WAIT,
					cdcs_pkg::ST_DONE: begin
						if (item.status_complete) begin
							nxt.seq = cdcs_pkg::ST_IDLE;
						end else begin
							issue   = 1'b1;
							nxt.seq = cdcs_pkg::ST_ERROR;
							code    = cdcs_pkg::CMD_NOP;
							unique case (cur.seq)
								cdcs_pkg::ST_SEEK_WAIT: nxt.err = cdcs_pkg::ERR_SEEK;
								cdcs_pkg::ST_DONE:      nxt.err = cdcs_pkg::ERR_GENERIC;
								default:                nxt.err = cdcs_pkg::ERR_READ;
							endcase
						end
					end
					cdcs_pkg::ST_ERROR: begin
						issue = 1'b1;
						// shell open keeps the error pending
						if (item.status_complete && !item.shell_open) begin
							nxt.seq = cdcs_pkg::ST_HANDLE_ERR;
							code    = cdcs_pkg::CMD_GETTN;
						end else begin
							code = cdcs_pkg::CMD_NOP;
						end
					end
					cdcs_pkg::ST_HANDLE_ERR: begin
						if (!item.status_complete) begin
							issue   = 1'b1;
							nxt.seq = cdcs_pkg::ST_ERROR;
							code    = cdcs_pkg::CMD_NOP;
						end else begin
							// retry according to the recorded error class
							issue = 1'b1;
							unique case (cur.err)
								cdcs_pkg::ERR_SEEK: begin
									nxt.seq = cdcs_pkg::ST_SEEK_SETLOC;
									code    = cdcs_pkg::CMD_SETLOC;
								end
								cdcs_pkg::ERR_GENERIC: begin
									nxt.seq = cdcs_pkg::ST_DONE;
									code    = cdcs_pkg::CMD_PAUSE;
								end
								cdcs_pkg::ERR_READ: begin
									nxt.seq = cdcs_pkg::ST_READ_RETRY;
									code    = cdcs_pkg::CMD_PAUSE;
								end
								cdcs_pkg::ERR_HALT: begin
									nxt.seq = cdcs_pkg::ST_HALT;
									code    = cdcs_pkg::CMD_STOP;
								end
								cdcs_pkg::ERR_AUDIO: begin
									nxt.seq = cdcs_pkg::ST_AUDIO_MODE;
									code    = cdcs_pkg::CMD_SETMODE;
								end
								cdcs_pkg::ERR_RESET: begin
									nxt.seq = cdcs_pkg::ST_RESET_MODE;
									code    = cdcs_pkg::CMD_SETMODE;
								end
								default: begin
									issue = 1'b0;
								end
							endcase
						end
					end
					default: begin
					end
				endcase
			end
			cdcs_pkg::KIND_READ: begin
				nxt.loc = item.target_location;
				nxt.seq = cdcs_pkg::ST_READ_SETLOC;
				issue   = 1'b1;
				code    = cdcs_pkg::CMD_SETLOC;
			end
			cdcs_pkg::KIND_SEEK: begin
				issue = 1'b1;
				if (item.pause_instead) begin
					nxt.seq = cdcs_pkg::ST_DONE;
					code    = cdcs_pkg::CMD_PAUSE;
				end else begin
					nxt.loc = item.target_location;
					nxt.seq = cdcs_pkg::ST_SEEK_SETLOC;
					code    = cdcs_pkg::CMD_SETLOC;
				end
			end
			cdcs_pkg::KIND_MODE: begin
				nxt.mode = item.mode_byte;
				nxt.seq  = cdcs_pkg::ST_RESET_MODE;
				issue    = 1'b1;
				code     = cdcs_pkg::CMD_SETMODE;
			end
			cdcs_pkg::KIND_CHAN: begin
				nxt.chan = item.channel_number;
			end
			default: begin
			end
		endcase
	end

	// command parameters come from the updated context
	always_comb begin
		res                  = '0;
		res.command_valid    = issue;
		res.drive_state      = nxt.seq;
		res.last_error       = nxt.err;
		res.idle             = (nxt.seq == cdcs_pkg::ST_IDLE);
		if (issue) begin
			res.command_code = code;
			unique case (code)
				cdcs_pkg::CMD_SETLOC: res.command_location = nxt.loc;
				cdcs_pkg::CMD_SETMODE: res.command_byte_a = nxt.mode;
				cdcs_pkg::CMD_SETFILTER: begin
					res.command_byte_a = cdcs_pkg::FILTER_FILE;
					res.command_byte_b = nxt.chan;
				end
				default: begin
				end
			endcase
		end
	end

endmodule

[src/cd_drive_command_sequencer_unit.sv]
// optical drive command sequencer
// slave channel (s_axis_*): one item per host request or drive completion event,
//   kind in tuser (0 event, 1 start read, 2 start seek or pause, 3 set mode,
//   4 set channel), the rest in tdata
// master channel (m_axis_*): exactly one item out per item in, carrying the
//   drive command to issue (if any) with its parameters, plus the sequencer
//   state, the last error class and an idle flag after the item
// flow: an accepted item is held in the input register, and its result is
//   loaded into the output register, which raises m_axis_tvalid, once that
//   register is free
// throughput: one item per cycle unless stalled; the transition is one pass of
//   logic between the input register and the output register, and the context
//   (state, error, location, mode, channel) updates as the result is loaded
// reset: arst_n clears both valid flags and puts the context at idle, no error,
//   location, mode and channel zero
// stall: while m_axis_tready is low the output item holds; the input register
//   keeps taking one more item, then s_axis_tready drops until the output drains
module cd_drive_command_sequencer_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [0] status_complete, [1] shell_open, [33:2] target_location,
	// [34] pause_instead, [42:35] mode_byte, [50:43] channel_number, [55:51] zero
	input  logic [55:0] s_axis_tdata,
	// [2:0] kind
	input  logic [2:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [0] command_valid, [4:1] command_code, [36:5] command_location,
	// [44:37] command_byte_a, [52:45] command_byte_b, [56:53] drive_state,
	// [59:57] last_error, [60] idle, [63:61] zero
	output logic [63:0] m_axis_tdata
);

	cdcs_pkg::item_t   item_s1;
	logic              valid_s1;
	cdcs_pkg::ctx_t    ctx_q;
	cdcs_pkg::ctx_t    ctx_nxt;
	cdcs_pkg::result_t res;
	cdcs_pkg::result_t res_s2;
	logic              valid_s2;
	logic              adv_s2;
	logic              adv_s1;

	// output register is free when empty or being drained
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || adv_s2;
	assign adv_s1        = s_axis_tvalid && s_axis_tready;

	// valid flags and context
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			ctx_q    <= '{seq: cdcs_pkg::ST_IDLE, err: cdcs_pkg::ERR_NONE,
				loc: '0, mode: '0, chan: '0};
		end else begin
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (adv_s2) begin
				valid_s2 <= valid_s1;
				if (valid_s1) begin
					ctx_q <= ctx_nxt;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			item_s1.kind            <= s_axis_tuser;
			item_s1.status_complete <= s_axis_tdata[0];
			item_s1.shell_open      <= s_axis_tdata[1];
			item_s1.target_location <= s_axis_tdata[33:2];
			item_s1.pause_instead   <= s_axis_tdata[34];
			item_s1.mode_byte       <= s_axis_tdata[42:35];
			item_s1.channel_number  <= s_axis_tdata[50:43];
		end
		if (adv_s2 && valid_s1) begin
			res_s2 <= res;
		end
	end

	cdcs_step u_step (
		.item (item_s1),
		.cur  (ctx_q),
		.nxt  (ctx_nxt),
		.res  (res)
	);

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {3'b000, res_s2.idle, res_s2.last_error, res_s2.drive_state,
		res_s2.command_byte_b, res_s2.command_byte_a, res_s2.command_location,
		res_s2.command_code, res_s2.command_valid};

endmodule

[src/cdcs_checker.sv]
module cdcs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [2:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [63:0] m_axis_tdata
);

	// idle flag tracks the reported state
	a_idle_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[60] == (m_axis_tdata[56:53] == cdcs_pkg::ST_IDLE)))
		else $error("idle flag disagrees with drive state");

	// no command means empty parameter fields
	a_no_cmd_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tdata[0]) |-> (m_axis_tdata[52:1] == '0))
		else $error("parameters present without a command");

	// location only travels with setloc
	a_loc_setloc: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[4:1] != cdcs_pkg::CMD_SETLOC)
		|-> (m_axis_tdata[36:5] == '0))
		else $error("location on a command other than setloc");

	// a start read issues setloc and lands in the read setloc state,
	// once the output register takes it
	a_read_start: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser == cdcs_pkg::KIND_READ)
		##1 (!m_axis_tvalid || m_axis_tready)
		|=> (m_axis_tvalid && m_axis_tdata[0]
			&& m_axis_tdata[4:1] == cdcs_pkg::CMD_SETLOC
			&& m_axis_tdata[56:53] == cdcs_pkg::ST_READ_SETLOC))
		else $error("start read did not issue setloc");

	// stalled output holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
		else $error("output item changed while stalled");

endmodule

bind cd_drive_command_sequencer_unit cdcs_checker u_cdcs_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
